// ===== rtl/bfrs_pkg.sv =====
// Package for the bit-field reader: field widths, opcodes, control states and
// the request and response structs. No dependencies.
package bfrs_pkg;

   localparam int WORD_BITS           = 16;
   localparam int DEFAULT_STORE_DEPTH = 1024;

   localparam int OPCODE_W     = 3;
   localparam int ADDR_FIELD_W = 10;
   localparam int BITPOS_W     = 4;
   localparam int COUNT_W      = 15;

   // Largest word step that a skip or rewind can request, and its width.
   localparam int MAX_STEP_WORDS = ((1 << COUNT_W) - 1 + WORD_BITS - 1) / WORD_BITS;
   localparam int STEP_W         = $clog2(MAX_STEP_WORDS + 1);
   // Shift index of the remainder sweep.
   localparam int SHIFT_IDX_W    = 4;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_COUNT = 1'b1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE  = 3'd0,
      OP_INIT   = 3'd1,
      OP_UNPL   = 3'd2,
      OP_UNPR   = 3'd3,
      OP_SKIP   = 3'd4,
      OP_REWIND = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_UPDATE,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]     opcode;
      logic [ADDR_FIELD_W-1:0] word_address;
      logic [WORD_BITS-1:0]    word_value;
      logic [BITPOS_W-1:0]     bit_position;
      logic [COUNT_W-1:0]      bit_count;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]    data_value;
      logic [ADDR_FIELD_W-1:0] word_pointer;
      logic [BITPOS_W-1:0]     bit_pointer;
      logic                    status;
   } rsp_type;

endpackage

// ===== rtl/bitfield_reader_seek.sv =====
// Top level of the bit-field reader over a store of 16-bit words.
// Depends on bfrs_pkg and bfrs_ram.
//
// Usage: a request is taken on the clock edge where start is high and busy
// is low; req_payload carries opcode, address, word, bit position and count.
// Every request gives exactly one response: rsp_strobe is high for one cycle
// with rsp_payload holding the field read and the read position afterwards.
// The receiver cannot stall; a response must be taken in the cycle it shows.
// The next request may be issued in the cycle the response is shown.
// Steps from the accepting edge: when STORE_DEPTH is not a power of two
// and at most 2048, a remainder sweep in ST_REDUCE, top shift first; then
// ST_UPDATE, and for some requests ST_LOAD after it:
//   write word, in-word unpack, bad count, in-word skip, unused opcodes:
//     response strobed from ST_UPDATE;
//   init, word-crossing unpack, crossing skip, rewind: one more state,
//     ST_LOAD, spent waiting on the store's registered read.
// The word store is single-port: one access per cycle.
// Reset clears the read position and the cached word; the store itself is
// not cleared and holds its contents until written.
module bitfield_reader_seek #(
   parameter int STORE_DEPTH = bfrs_pkg::DEFAULT_STORE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  bfrs_pkg::req_type req_payload,
   output logic              busy,
   output logic              rsp_strobe,
   output bfrs_pkg::rsp_type rsp_payload
);

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int WB     = bfrs_pkg::WORD_BITS;
   localparam int RED_W  = bfrs_pkg::STEP_W;
   localparam int SH_W   = bfrs_pkg::SHIFT_IDX_W;

   // A remainder sweep is needed only for a depth that is not a power of two
   // and small enough for a word step or address to exceed it.
   localparam bit NEED_RED = ((STORE_DEPTH & (STORE_DEPTH - 1)) != 0) &&
                             (STORE_DEPTH <= bfrs_pkg::MAX_STEP_WORDS);

   function automatic int red_top(input int depth);
      int k;
      k = 0;
      while ((depth << (k + 1)) <= bfrs_pkg::MAX_STEP_WORDS) k = k + 1;
      return k;
   endfunction

   localparam int RED_TOP = NEED_RED ? red_top(STORE_DEPTH) : 0;

   // Addition and subtraction of two in-range word addresses, modulo depth.
   function automatic logic [ADDR_W-1:0] mod_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (ADDR_W+1)'(STORE_DEPTH)) sum = sum - (ADDR_W+1)'(STORE_DEPTH);
      return sum[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] mod_sub(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] diff;
      diff = {1'b0, a} - {1'b0, b};
      if (diff[ADDR_W]) diff = diff + (ADDR_W+1)'(STORE_DEPTH);
      return diff[ADDR_W-1:0];
   endfunction

   // Right-justified unpack moves the field from the top bits to the bottom.
   function automatic logic [WB-1:0] justify(input logic [WB-1:0] v,
                                             input logic [4:0]    n,
                                             input logic          right);
      logic [WB-1:0] r;
      r = v;
      if (right) r = v >> (5'(WB) - n);
      return r;
   endfunction

   // Control and position state.
   bfrs_pkg::state_type state_ff, state_in;
   bfrs_pkg::req_type   req_ff, req_in;
   logic [ADDR_W-1:0]   word_ptr_ff, word_ptr_in;
   logic [3:0]          bit_ptr_ff, bit_ptr_in;
   logic [WB-1:0]       cache_ff, cache_in;
   logic [RED_W-1:0]    red_ff, red_in;
   logic [SH_W-1:0]     step_ff, step_in;
   logic [WB-1:0]       acc_ff, acc_in;
   logic [3:0]          old_bit_ff, old_bit_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   bfrs_pkg::rsp_type   rsp_ff, rsp_in;

   // Word store port.
   logic              ram_en;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [WB-1:0]     ram_wdata;
   logic [WB-1:0]     ram_rdata;

   // Datapath terms.
   bfrs_pkg::op_type  acc_op;
   logic [15:0]       acc_skip_total;
   logic [RED_W-1:0]  acc_rew_words;
   logic [RED_W-1:0]  red_start;
   logic [RED_W:0]    red_sub;
   bfrs_pkg::op_type  op;
   logic              is_unpack;
   logic              count_ok;
   logic [4:0]        n5;
   logic [4:0]        sum5;
   logic [WB-1:0]     mask;
   logic [2*WB-1:0]   cache_shift;
   logic [2*WB-1:0]   next_shift;
   logic [WB-1:0]     part1;
   logic [WB-1:0]     merged;
   logic [15:0]       skip_total;
   logic [ADDR_W-1:0] red_mod;
   logic [ADDR_W-1:0] ptr_inc;
   logic [ADDR_W-1:0] ptr_fwd;
   logic [ADDR_W-1:0] ptr_back;
   logic              load_go;

   bfrs_ram #(
      .WIDTH(WB),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock(clock),
      .en   (ram_en),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   // The value that needs a reduction modulo depth: the store address for
   // write and init, the word step for skip and rewind.
   always_comb begin
      acc_op         = bfrs_pkg::op_type'(req_payload.opcode);
      acc_skip_total = 16'(bit_ptr_ff) + 16'(req_payload.bit_count);
      acc_rew_words  = RED_W'(req_payload.bit_count[bfrs_pkg::COUNT_W-1:4]) +
                       RED_W'(req_payload.bit_count[3:0] > bit_ptr_ff);
      unique case (acc_op)
         bfrs_pkg::OP_WRITE,
         bfrs_pkg::OP_INIT:   red_start = RED_W'(req_payload.word_address);
         bfrs_pkg::OP_SKIP:   red_start = acc_skip_total[15:4];
         bfrs_pkg::OP_REWIND: red_start = acc_rew_words;
         default:             red_start = '0;
      endcase
   end

   // Decode of the held request and the address arithmetic.
   always_comb begin
      op          = bfrs_pkg::op_type'(req_ff.opcode);
      is_unpack   = (op == bfrs_pkg::OP_UNPL) || (op == bfrs_pkg::OP_UNPR);
      count_ok    = (req_ff.bit_count != '0) &&
                    (req_ff.bit_count <= bfrs_pkg::COUNT_W'(WB));
      n5          = req_ff.bit_count[4:0];
      sum5        = 5'(bit_ptr_ff) + n5;
      mask        = {WB{1'b1}} << (5'(WB) - n5);
      cache_shift = (2*WB)'(cache_ff) << bit_ptr_ff;
      part1       = cache_shift[WB-1:0] & mask;
      next_shift  = (2*WB)'(ram_rdata) << old_bit_ff;
      merged      = acc_ff | (next_shift[2*WB-1:WB] & mask);
      skip_total  = 16'(bit_ptr_ff) + 16'(req_ff.bit_count);
      red_mod     = ADDR_W'(red_ff);
      red_sub     = (RED_W+1)'(STORE_DEPTH) << step_ff;
      ptr_inc     = mod_add(word_ptr_ff, ADDR_W'(1));
      ptr_fwd     = mod_add(word_ptr_ff, red_mod);
      ptr_back    = mod_sub(word_ptr_ff, red_mod);
      load_go     = (op == bfrs_pkg::OP_INIT) ||
                    (is_unpack && count_ok && sum5[4]) ||
                    ((op == bfrs_pkg::OP_SKIP) && (skip_total[15:4] != '0)) ||
                    (op == bfrs_pkg::OP_REWIND);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfrs_pkg::ST_IDLE: begin
            if (start) state_in = NEED_RED ? bfrs_pkg::ST_REDUCE : bfrs_pkg::ST_UPDATE;
         end
         bfrs_pkg::ST_REDUCE: begin
            if (step_ff == '0) state_in = bfrs_pkg::ST_UPDATE;
         end
         bfrs_pkg::ST_UPDATE: begin
            state_in = load_go ? bfrs_pkg::ST_LOAD : bfrs_pkg::ST_IDLE;
         end
         bfrs_pkg::ST_LOAD: begin
            state_in = bfrs_pkg::ST_IDLE;
         end
         default: state_in = bfrs_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath register updates.
   always_comb begin
      req_in        = req_ff;
      word_ptr_in   = word_ptr_ff;
      bit_ptr_in    = bit_ptr_ff;
      cache_in      = cache_ff;
      red_in        = red_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      old_bit_in    = old_bit_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_en        = 1'b0;
      ram_we        = 1'b0;
      ram_addr      = word_ptr_ff;
      ram_wdata     = req_ff.word_value;
      unique case (state_ff)
         bfrs_pkg::ST_IDLE: begin
            if (start) begin
               req_in  = req_payload;
               red_in  = red_start;
               step_in = SH_W'(RED_TOP);
            end
         end
         bfrs_pkg::ST_REDUCE: begin
            // One restoring step of the remainder per cycle, top shift first.
            if ({1'b0, red_ff} >= red_sub) red_in = RED_W'({1'b0, red_ff} - red_sub);
            step_in = step_ff - SH_W'(1);
         end
         bfrs_pkg::ST_UPDATE: begin
            rsp_in.data_value = '0;
            rsp_in.status     = bfrs_pkg::STATUS_OK;
            unique case (op)
               bfrs_pkg::OP_WRITE: begin
                  ram_en   = 1'b1;
                  ram_we   = 1'b1;
                  ram_addr = red_mod;
               end
               bfrs_pkg::OP_INIT: begin
                  ram_en      = 1'b1;
                  ram_addr    = red_mod;
                  word_ptr_in = red_mod;
                  bit_ptr_in  = req_ff.bit_position;
               end
               bfrs_pkg::OP_UNPL,
               bfrs_pkg::OP_UNPR: begin
                  if (!count_ok) begin
                     rsp_in.status = bfrs_pkg::STATUS_BAD_COUNT;
                  end else if (!sum5[4]) begin
                     bit_ptr_in        = sum5[3:0];
                     rsp_in.data_value = justify(part1, n5, op == bfrs_pkg::OP_UNPR);
                  end else begin
                     // The field runs into the next word: fetch it.
                     bit_ptr_in  = sum5[3:0];
                     word_ptr_in = ptr_inc;
                     ram_en      = 1'b1;
                     ram_addr    = ptr_inc;
                     acc_in      = part1;
                     old_bit_in  = bit_ptr_ff;
                  end
               end
               bfrs_pkg::OP_SKIP: begin
                  bit_ptr_in = skip_total[3:0];
                  if (skip_total[15:4] != '0) begin
                     word_ptr_in = ptr_fwd;
                     ram_en      = 1'b1;
                     ram_addr    = ptr_fwd;
                  end
               end
               bfrs_pkg::OP_REWIND: begin
                  // A borrow from the bit offset wraps within four bits.
                  bit_ptr_in  = bit_ptr_ff - req_ff.bit_count[3:0];
                  word_ptr_in = ptr_back;
                  ram_en      = 1'b1;
                  ram_addr    = ptr_back;
               end
               default: begin
               end
            endcase
            if (!load_go) begin
               rsp_strobe_in       = 1'b1;
               rsp_in.word_pointer = bfrs_pkg::ADDR_FIELD_W'(word_ptr_in);
               rsp_in.bit_pointer  = bit_ptr_in;
            end
         end
         bfrs_pkg::ST_LOAD: begin
            cache_in            = ram_rdata;
            rsp_strobe_in       = 1'b1;
            rsp_in.word_pointer = bfrs_pkg::ADDR_FIELD_W'(word_ptr_ff);
            rsp_in.bit_pointer  = bit_ptr_ff;
            rsp_in.status       = bfrs_pkg::STATUS_OK;
            rsp_in.data_value   = is_unpack ?
                                  justify(merged, n5, op == bfrs_pkg::OP_UNPR) : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bfrs_pkg::ST_IDLE;
         word_ptr_ff   <= '0;
         bit_ptr_ff    <= '0;
         cache_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         word_ptr_ff   <= word_ptr_in;
         bit_ptr_ff    <= bit_ptr_in;
         cache_ff      <= cache_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      red_ff     <= red_in;
      step_ff    <= step_in;
      acc_ff     <= acc_in;
      old_bit_ff <= old_bit_in;
      rsp_ff     <= rsp_in;
   end

   assign busy        = (state_ff != bfrs_pkg::ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/bfrs_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module bfrs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== tb/sv/bfrs_checker.sv =====
// Response checker for the bit-field reader: keeps its own copy of the word
// store and read position, predicts one response per request and compares.
// Depends on bfrs_pkg.
module bfrs_checker
   import bfrs_pkg::*;
#(
   parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_payload,
   input  logic    rsp_strobe,
   input  rsp_type rsp_payload,
   output int      outstanding,
   output int      fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_LIMIT = 100;

   logic [WORD_BITS-1:0] shadow_store [STORE_DEPTH];
   int unsigned          word_ptr;
   int unsigned          bit_ptr;
   logic [WORD_BITS-1:0] cached_word;
   rsp_type              due_responses [$];
   int                   printed;

   initial begin
      fail_count  = 0;
      outstanding = 0;
      printed     = 0;
      word_ptr    = 0;
      bit_ptr     = 0;
      cached_word = '0;
      foreach (shadow_store[i]) shadow_store[i] = '0;
   end

   task automatic report_mismatch(string what);
      if (printed < PRINT_LIMIT) $display("[%0t] checker: %s", $time, what);
      printed++;
      fail_count++;
   endtask

   // Applies one request to the shadow state and returns the response it causes.
   function automatic rsp_type step_reader(req_type r);
      rsp_type              rsp;
      int unsigned          n, total, words, rem, old_bit;
      logic [WORD_BITS-1:0] mask, field;
      rsp = '0;
      n   = r.bit_count;
      case (op_type'(r.opcode))
         OP_WRITE: shadow_store[r.word_address % STORE_DEPTH] = r.word_value;
         OP_INIT: begin
            word_ptr    = r.word_address % STORE_DEPTH;
            bit_ptr     = r.bit_position;
            cached_word = shadow_store[word_ptr];
         end
         OP_UNPL, OP_UNPR: begin
            if (n == 0 || n > WORD_BITS) begin
               rsp.status = STATUS_BAD_COUNT;
            end else begin
               mask    = '1 << (WORD_BITS - n);
               field   = (cached_word << bit_ptr) & mask;
               old_bit = bit_ptr;
               bit_ptr += n;
               // The field runs into the next word, which is fetched fresh.
               if (bit_ptr >= WORD_BITS) begin
                  word_ptr    = (word_ptr + 1) % STORE_DEPTH;
                  cached_word = shadow_store[word_ptr];
                  bit_ptr    -= WORD_BITS;
                  field      |= (cached_word >> (WORD_BITS - old_bit)) & mask;
               end
               if (r.opcode == OP_UNPR) field = field >> (WORD_BITS - n);
               rsp.data_value = field;
            end
         end
         OP_SKIP: begin
            total   = bit_ptr + n;
            words   = total / WORD_BITS;
            bit_ptr = total % WORD_BITS;
            if (words > 0) begin
               word_ptr    = (word_ptr + words) % STORE_DEPTH;
               cached_word = shadow_store[word_ptr];
            end
         end
         OP_REWIND: begin
            words = n / WORD_BITS;
            rem   = n % WORD_BITS;
            if (rem > bit_ptr) begin
               words++;
               bit_ptr = bit_ptr + WORD_BITS - rem;
            end else begin
               bit_ptr -= rem;
            end
            word_ptr    = (word_ptr + STORE_DEPTH - words % STORE_DEPTH) % STORE_DEPTH;
            cached_word = shadow_store[word_ptr];
         end
         default: ;
      endcase
      rsp.word_pointer = word_ptr;
      rsp.bit_pointer  = bit_ptr;
      return rsp;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         word_ptr    = 0;
         bit_ptr     = 0;
         cached_word = '0;
         due_responses.delete();
      end else begin
         // Responses are matched before this edge's request is predicted.
         if (rsp_strobe) begin
            if (due_responses.size() == 0) begin
               report_mismatch($sformatf("response %p with no request waiting", rsp_payload));
            end else begin
               want = due_responses.pop_front();
               if (rsp_payload.data_value !== want.data_value)
                  report_mismatch($sformatf("data_value %h, expected %h",
                                            rsp_payload.data_value, want.data_value));
               if (rsp_payload.word_pointer !== want.word_pointer)
                  report_mismatch($sformatf("word_pointer %0d, expected %0d",
                                            rsp_payload.word_pointer, want.word_pointer));
               if (rsp_payload.bit_pointer !== want.bit_pointer)
                  report_mismatch($sformatf("bit_pointer %0d, expected %0d",
                                            rsp_payload.bit_pointer, want.bit_pointer));
               if (rsp_payload.status !== want.status)
                  report_mismatch($sformatf("status %b, expected %b",
                                            rsp_payload.status, want.status));
            end
         end
         if (start && !busy) due_responses.push_back(step_reader(req_payload));
      end
      outstanding <= due_responses.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the bit-field reader testbench: clock, reset, request stimulus,
// watchdog and verdict. Depends on bfrs_pkg, bitfield_reader_seek and bfrs_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bfrs_pkg::*;

   localparam int DEPTH           = DEFAULT_STORE_DEPTH;
   localparam int RANDOM_REQUESTS = 600;
   // The final stretch of random requests runs back to back with no idling.
   localparam int CALM_TAIL       = 100;
   // A healthy run stays well inside this limit between handshakes.
   localparam int WATCHDOG_LIMIT  = 200;
   localparam int DRAIN_CYCLES    = 8;
   localparam int MAX_COUNT       = (1 << COUNT_W) - 1;

   // Opcodes the block does not define; they must leave the state alone.
   localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_payload;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   int      outstanding;
   int      fail_count;
   int      quiet_cycles = 0;
   bit      idling_on;

   bitfield_reader_seek #(.STORE_DEPTH(DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   bfrs_checker #(.STORE_DEPTH(DEPTH)) resp_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The watchdog counts cycles in which neither a request nor a response is
   // taken. A hung block or a lost response ends the run here.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_request(logic [OPCODE_W-1:0] op, int addr, int val,
                                            int pos, int cnt);
      req_type r;
      r.opcode       = op;
      r.word_address = addr;
      r.word_value   = val;
      r.bit_position = pos;
      r.bit_count    = cnt;
      return r;
   endfunction

   // Every field starts fully random, so the bits an opcode ignores still
   // toggle. The store is completely written before any of these are sent,
   // so any init, skip or rewind target is safe to read.
   function automatic req_type random_request();
      logic [$bits(req_type)-1:0] raw;
      req_type                    r;
      int unsigned                pick;
      raw  = {$urandom, $urandom};
      r    = raw;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         r.opcode = OP_WRITE;
      end else if (pick < 20) begin
         r.opcode = OP_INIT;
      end else if (pick < 70) begin
         // Mostly legal counts so the read position walks across many words;
         // one in ten is a bad count, zero or above a word.
         r.opcode = $urandom_range(0, 1) ? OP_UNPL : OP_UNPR;
         if ($urandom_range(0, 9) != 0) r.bit_count = $urandom_range(1, WORD_BITS);
         else if ($urandom_range(0, 1)) r.bit_count = 0;
         else r.bit_count = $urandom_range(WORD_BITS + 1, MAX_COUNT);
      end else if (pick < 94) begin
         // Short moves stay near the field being read; the rest keep the full
         // random count and can wrap the store up to twice over.
         r.opcode = (pick < 82) ? OP_SKIP : OP_REWIND;
         if ($urandom_range(0, 2) != 0) r.bit_count = $urandom_range(0, 3 * WORD_BITS);
      end else begin
         r.opcode = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      end
      return r;
   endfunction

   // Holds start high until the block takes the request, then may insert a
   // burst of idle cycles. Without a burst, start simply stays high and the
   // next request follows on the very next edge the block allows.
   task automatic send_request(req_type r);
      req_payload <= r;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      idling_on   = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Right after reset the cached word is zero and the
      // pointers are at the origin; these first requests read only that cache.
      send_request(make_request(OP_UNPR, 0, 0, 0, 4));
      send_request(make_request(OP_SPARE_6, DEPTH - 1, 16'hFFFF, 15, MAX_COUNT));
      send_request(make_request(OP_SPARE_7, 0, 0, 0, 0));
      send_request(make_request(OP_UNPL, 0, 0, 0, 0));
      send_request(make_request(OP_UNPR, 0, 0, 0, WORD_BITS + 1));
      send_request(make_request(OP_UNPL, 0, 0, 0, MAX_COUNT));
      // A skip that stays inside the current word must not reload the cache.
      send_request(make_request(OP_SKIP, 0, 0, 0, 11));
      send_request(make_request(OP_WRITE, 0, 16'hA5C3, 0, 0));
      send_request(make_request(OP_WRITE, 1, 16'h8001, 0, 0));
      send_request(make_request(OP_WRITE, 2, 16'h0000, 0, 0));
      send_request(make_request(OP_WRITE, DEPTH - 1, 16'hFFFF, 0, 0));
      // Start on the last bit of the last word: a full-width field wraps to
      // word zero, and a one-bit field then lands exactly on the boundary.
      send_request(make_request(OP_INIT, DEPTH - 1, 0, 15, 0));
      send_request(make_request(OP_UNPL, 0, 0, 0, WORD_BITS));
      send_request(make_request(OP_UNPR, 0, 0, 0, 1));
      // Overwrite the word now held in the cache; the old value must still
      // be what the next in-word field sees.
      send_request(make_request(OP_WRITE, 1, 16'h7FFE, 0, 0));
      send_request(make_request(OP_UNPR, 0, 0, 0, 8));
      send_request(make_request(OP_SKIP, 0, 0, 0, 3));
      send_request(make_request(OP_SKIP, 0, 0, 0, 5));
      // Rewind always reloads, so the overwritten value shows up now.
      send_request(make_request(OP_REWIND, 0, 0, 0, WORD_BITS));
      send_request(make_request(OP_UNPL, 0, 0, 0, WORD_BITS));
      send_request(make_request(OP_REWIND, 0, 0, 0, MAX_COUNT));
      send_request(make_request(OP_SKIP, 0, 0, 0, MAX_COUNT));
      send_request(make_request(OP_REWIND, 0, 0, 0, 0));
      send_request(make_request(OP_SKIP, 0, 0, 0, 0));
      send_request(make_request(OP_INIT, 0, 0, 0, 0));
      send_request(make_request(OP_UNPR, 0, 0, 0, WORD_BITS));
      // From word one, bit zero: this rewind wraps back to the last word.
      send_request(make_request(OP_REWIND, 0, 0, 0, WORD_BITS + 1));

      // Fill the whole store so that no later request can read a word that
      // was never written.
      for (int a = 0; a < DEPTH; a++) begin
         send_request(make_request(OP_WRITE, a, $urandom_range(0, 16'hFFFF),
                                   $urandom_range(0, 15), $urandom_range(0, MAX_COUNT)));
      end

      // Random part. Idling is switched on and off in stretches, and the
      // tail runs with none at all.
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i >= RANDOM_REQUESTS - CALM_TAIL) idling_on = 1'b0;
         else if (i % 50 == 0) idling_on = ($urandom_range(0, 2) != 0);
         send_request(random_request());
      end
      start <= 1'b0;

      // The checker's count is registered, so look from the next edge on.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bfrs_pkg.sv
rtl/bfrs_ram.sv
rtl/bitfield_reader_seek.sv
tb/sv/bfrs_checker.sv
tb/sv/tb.sv
